@@ design/triangle_tangent_space_core_assert.svh @@
// assertion macros shared by the tangent space core
`ifndef TRIANGLE_TANGENT_SPACE_CORE_ASSERT_SVH
`define TRIANGLE_TANGENT_SPACE_CORE_ASSERT_SVH

// checked outside reset
`define TTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define TTS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ design/tts_pkg.sv @@
package tts_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int COORD_W     = 32;
  localparam int UNIT_W      = FRAC_BITS + 2;
  localparam int OP_W        = COORD_W + 1;
  localparam int PROD_W      = 2 * OP_W;
  localparam int ACC_W       = PROD_W + 2;
  localparam int DEN_W       = PROD_W;
  localparam int NUM_W       = DEN_W + FRAC_BITS;
  localparam int REM_W       = DEN_W + 1;
  localparam int CNT_W       = 7;
  localparam int LONG_STEPS  = NUM_W;
  localparam int SHORT_STEPS = COORD_W + FRAC_BITS;
  localparam int SQRT_STEPS  = COORD_W;
  localparam int IN_W        = 8 * COORD_W;
  localparam int OUT_BITS    = 6 * UNIT_W + 3 * COORD_W;
  localparam int OUT_W       = ((OUT_BITS + 7) / 8) * 8;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [UNIT_W-1:0]  unit_t;
  typedef logic signed [OP_W-1:0]    oper_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [ACC_W-1:0]   acc_t;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_ACC, S_POST, S_ITER, S_UNIT, S_UDIV, S_OUT
  } tts_state_e;

  typedef enum logic [2:0] {
    TK_DET, TK_TAN, TK_BIT, TK_DOT, TK_ORT, TK_SQT, TK_SQN
  } tts_task_e;

  typedef enum logic [1:0] {
    IT_DIV_LONG, IT_DIV_SHORT, IT_SQRT
  } tts_iter_op_e;

  typedef struct packed {
    logic         start;
    tts_iter_op_e op;
  } tts_iter_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } tts_iter_stat_t;

  // clip a wide signed value to the coordinate range
  function automatic coord_t sat_coord(input acc_t x);
    acc_t hi;
    acc_t lo;
    hi = ACC_W'({1'b0, {(COORD_W-1){1'b1}}});
    lo = -hi - ACC_W'(1);
    if (x > hi)      return coord_t'(hi);
    else if (x < lo) return coord_t'(lo);
    else             return x[COORD_W-1:0];
  endfunction

  // signed result of an unsigned quotient, clipped to the coordinate range
  function automatic coord_t sat_quot(input logic [NUM_W-1:0] q, input logic neg);
    logic [NUM_W-1:0] pmax;
    pmax = NUM_W'({1'b0, {(COORD_W-1){1'b1}}});
    if (!neg) begin
      if (q > pmax) return coord_t'(pmax);
      else          return q[COORD_W-1:0];
    end else begin
      if (q > pmax + NUM_W'(1)) return coord_t'(-(pmax + NUM_W'(1)));
      else                      return coord_t'(-q[COORD_W-1:0]);
    end
  endfunction

  function automatic logic [COORD_W-1:0] mag_coord(input coord_t v);
    if (v[COORD_W-1]) return COORD_W'(-v);
    else              return v;
  endfunction

endpackage

@@ design/tts_mul.sv @@
module tts_mul (
  input  logic              clk_i,
  input  logic              en_i,
  input  tts_pkg::oper_t    a_i,
  input  tts_pkg::oper_t    b_i,
  output tts_pkg::prod_t    prod_o
);

  tts_pkg::prod_t prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= a_i * b_i;
    end
  end

  assign prod_o = prod_q;

endmodule

@@ design/tts_iter.sv @@
module tts_iter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tts_pkg::tts_iter_req_t      req_i,
  input  logic [tts_pkg::NUM_W-1:0]   num_i,
  input  logic [tts_pkg::DEN_W-1:0]   den_i,
  output tts_pkg::tts_iter_stat_t     stat_o,
  output logic [tts_pkg::NUM_W-1:0]   quot_o
);

  logic                        busy_q, done_q, sqrt_q;
  logic [tts_pkg::CNT_W-1:0]   cnt_q;
  logic [tts_pkg::NUM_W-1:0]   num_q, quot_q;
  logic [tts_pkg::DEN_W-1:0]   den_q;
  logic [tts_pkg::REM_W-1:0]   rem_q;
  logic [tts_pkg::REM_W-1:0]   r_div, r_sq, r_cur, trial, diff;
  logic                        ge;
  logic [tts_pkg::CNT_W-1:0]   steps;

  // restoring divide: one quotient bit a cycle; root: one result bit a cycle
  always_comb begin
    r_div = {rem_q[tts_pkg::REM_W-2:0], num_q[tts_pkg::NUM_W-1]};
    r_sq  = {rem_q[tts_pkg::REM_W-3:0], num_q[tts_pkg::NUM_W-1 -: 2]};
    r_cur = sqrt_q ? r_sq : r_div;
    trial = sqrt_q ? {quot_q[tts_pkg::REM_W-3:0], 2'b01} : {1'b0, den_q};
    ge    = (r_cur >= trial);
    diff  = r_cur - trial;
  end

  always_comb begin
    case (req_i.op)
      tts_pkg::IT_DIV_LONG:  steps = tts_pkg::CNT_W'(tts_pkg::LONG_STEPS);
      tts_pkg::IT_DIV_SHORT: steps = tts_pkg::CNT_W'(tts_pkg::SHORT_STEPS);
      tts_pkg::IT_SQRT:      steps = tts_pkg::CNT_W'(tts_pkg::SQRT_STEPS);
      default:               steps = tts_pkg::CNT_W'(tts_pkg::LONG_STEPS);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - tts_pkg::CNT_W'(1);
        if (cnt_q == tts_pkg::CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      sqrt_q <= (req_i.op == tts_pkg::IT_SQRT);
      num_q  <= num_i;
      den_q  <= den_i;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? diff : r_cur;
      quot_q <= {quot_q[tts_pkg::NUM_W-2:0], ge};
      num_q  <= sqrt_q ? (num_q << 2) : (num_q << 1);
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quot_q;

endmodule

@@ design/triangle_tangent_space_core.sv @@
// triangle tangent space core
// slave stream: one beat per vertex (position, uv, normal, all signed q16.16).
// vertices group in threes; the first two of a triangle are held. the third
// starts the triangle: det, tangent and bitangent, then for each vertex the
// orthogonalized unit tangent and the unit normal.
// master stream: three beats per triangle, one per vertex in arrival order,
// tlast on the third, tuser high when the uv determinant is zero (tangent and
// bitangent then zero). a trailing partial triangle just stays held.
// a degenerate triangle skips the tangent and bitangent quotients and a
// zero-length vector skips its divides.
// the bottleneck is the bit-serial divide/root unit: 82 steps per tangent or
// bitangent quotient, 48 per unit component, 32 per root, with one shared
// 33x33 multiplier feeding the sums.
// tready is high only while the sequencer is idle; the next vertex may be
// taken while the last result still sits in the output register.
// a stalled receiver holds the sequencer before each result until the output
// register frees. reset clears the vertex phase and the output valid.
`include "triangle_tangent_space_core_assert.svh"

module triangle_tangent_space_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z
  input  logic [tts_pkg::IN_W-1:0]    s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // tangent_x/y/z, bitangent_x/y/z, unit_normal_x/y/z, zero fill
  output logic [tts_pkg::OUT_W-1:0]   m_axis_tdata,
  // degenerate
  output logic                        m_axis_tuser,
  // last_of_triangle
  output logic                        m_axis_tlast
);

  localparam int CW = tts_pkg::COORD_W;
  localparam int UW = tts_pkg::UNIT_W;

  tts_pkg::tts_state_e state_q, state_d;
  tts_pkg::tts_task_e  task_q, task_d;
  logic [1:0]          phase_q, phase_d, m_q, m_d, j_q, j_d, k_q, k_d;
  logic                out_valid_q, out_valid_d;

  // vertex store: slots 0 and 1 held, slot 2 the triggering vertex
  tts_pkg::coord_t p0_q [3], p1_q [3], p2_q [3];
  tts_pkg::coord_t n0_q [3], n1_q [3], n2_q [3];
  tts_pkg::coord_t uv0_q [2], uv1_q [2], uv2_q [2];

  tts_pkg::coord_t tan_q [3], tan_d [3];
  tts_pkg::coord_t bit_q [3], bit_d [3];
  tts_pkg::coord_t tp_q [3], tp_d [3];
  tts_pkg::coord_t wn_q [3], wn_d [3];
  tts_pkg::unit_t  ut_q [3], ut_d [3];
  tts_pkg::unit_t  un_q [3], un_d [3];
  tts_pkg::coord_t d_q, d_d;
  tts_pkg::acc_t   acc_q, acc_d, det_q, det_d;
  logic [CW-1:0]   len_q, len_d;
  logic            degen_q, degen_d, neg_q, neg_d;
  logic [tts_pkg::OUT_W-1:0] tdata_q, tdata_d;
  logic            tlast_q, tlast_d, tuser_q, tuser_d;

  tts_pkg::oper_t  e1 [3], e2 [3];
  tts_pkg::oper_t  du1, dv1, du2, dv2;
  tts_pkg::oper_t  mul_a, mul_b;
  logic            mul_en, mul_sub;
  tts_pkg::prod_t  prod;

  tts_pkg::tts_iter_req_t  iter_req;
  tts_pkg::tts_iter_stat_t iter_stat;
  logic [tts_pkg::NUM_W-1:0] iter_num, iter_quot;
  logic [tts_pkg::DEN_W-1:0] iter_den;

  logic            in_beat, out_load;
  tts_pkg::acc_t   abs_acc, abs_det;
  tts_pkg::coord_t uvec;
  logic [tts_pkg::NUM_W-1:0] tri_quot;

  assign s_axis_tready = (state_q == tts_pkg::S_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  // edge and uv deltas, exact in 33 bits
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1[i] = tts_pkg::OP_W'(p1_q[i]) - tts_pkg::OP_W'(p0_q[i]);
      e2[i] = tts_pkg::OP_W'(p2_q[i]) - tts_pkg::OP_W'(p0_q[i]);
    end
    du1 = tts_pkg::OP_W'(uv1_q[0]) - tts_pkg::OP_W'(uv0_q[0]);
    dv1 = tts_pkg::OP_W'(uv1_q[1]) - tts_pkg::OP_W'(uv0_q[1]);
    du2 = tts_pkg::OP_W'(uv2_q[0]) - tts_pkg::OP_W'(uv0_q[0]);
    dv2 = tts_pkg::OP_W'(uv2_q[1]) - tts_pkg::OP_W'(uv0_q[1]);
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_sub = 1'b0;
    case (task_q)
      tts_pkg::TK_DET: begin
        mul_a   = (m_q == 2'd0) ? du1 : dv1;
        mul_b   = (m_q == 2'd0) ? dv2 : du2;
        mul_sub = (m_q != 2'd0);
      end
      tts_pkg::TK_TAN: begin
        mul_a   = (m_q == 2'd0) ? e1[j_q] : e2[j_q];
        mul_b   = (m_q == 2'd0) ? dv2 : dv1;
        mul_sub = (m_q != 2'd0);
      end
      tts_pkg::TK_BIT: begin
        mul_a   = (m_q == 2'd0) ? e2[j_q] : e1[j_q];
        mul_b   = (m_q == 2'd0) ? du1 : du2;
        mul_sub = (m_q != 2'd0);
      end
      tts_pkg::TK_DOT: begin
        mul_a = tts_pkg::OP_W'(wn_q[m_q]);
        mul_b = tts_pkg::OP_W'(tan_q[m_q]);
      end
      tts_pkg::TK_ORT: begin
        mul_a = tts_pkg::OP_W'(wn_q[j_q]);
        mul_b = tts_pkg::OP_W'(d_q);
      end
      tts_pkg::TK_SQT: begin
        mul_a = tts_pkg::OP_W'(tp_q[m_q]);
        mul_b = tts_pkg::OP_W'(tp_q[m_q]);
      end
      tts_pkg::TK_SQN: begin
        mul_a = tts_pkg::OP_W'(wn_q[m_q]);
        mul_b = tts_pkg::OP_W'(wn_q[m_q]);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  tts_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  tts_iter u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (iter_req),
    .num_i  (iter_num),
    .den_i  (iter_den),
    .stat_o (iter_stat),
    .quot_o (iter_quot)
  );

  assign abs_acc  = acc_q[tts_pkg::ACC_W-1] ? -acc_q : acc_q;
  assign abs_det  = det_q[tts_pkg::ACC_W-1] ? -det_q : det_q;
  assign uvec     = (task_q == tts_pkg::TK_SQT) ? tp_q[j_q] : wn_q[j_q];
  assign tri_quot = iter_quot;
  assign out_load = (state_q == tts_pkg::S_OUT) && (!out_valid_q || m_axis_tready);

  // sequencer
  always_comb begin
    state_d     = state_q;
    task_d      = task_q;
    phase_d     = phase_q;
    m_d         = m_q;
    j_d         = j_q;
    k_d         = k_q;
    out_valid_d = out_valid_q;
    tan_d       = tan_q;
    bit_d       = bit_q;
    tp_d        = tp_q;
    wn_d        = wn_q;
    ut_d        = ut_q;
    un_d        = un_q;
    d_d         = d_q;
    acc_d       = acc_q;
    det_d       = det_q;
    len_d       = len_q;
    degen_d     = degen_q;
    neg_d       = neg_q;
    tdata_d     = tdata_q;
    tlast_d     = tlast_q;
    tuser_d     = tuser_q;
    mul_en      = 1'b0;
    iter_req    = '{start: 1'b0, op: tts_pkg::IT_DIV_LONG};
    iter_num    = '0;
    iter_den    = '0;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      tts_pkg::S_IDLE: begin
        if (in_beat) begin
          if (phase_q == 2'd1) begin
            phase_d = 2'd2;
          end else if (phase_q == 2'd2) begin
            phase_d = 2'd0;
            task_d  = tts_pkg::TK_DET;
            m_d     = 2'd0;
            acc_d   = '0;
            state_d = tts_pkg::S_MUL;
          end else begin
            phase_d = 2'd1;
          end
        end
      end
      tts_pkg::S_MUL: begin
        mul_en  = 1'b1;
        state_d = tts_pkg::S_ACC;
      end
      tts_pkg::S_ACC: begin
        acc_d = mul_sub ? acc_q - tts_pkg::ACC_W'(prod) : acc_q + tts_pkg::ACC_W'(prod);
        if ((task_q == tts_pkg::TK_ORT) ||
            (((task_q == tts_pkg::TK_DET) || (task_q == tts_pkg::TK_TAN) ||
              (task_q == tts_pkg::TK_BIT)) && (m_q == 2'd1)) ||
            (m_q == 2'd2)) begin
          state_d = tts_pkg::S_POST;
        end else begin
          m_d     = m_q + 2'd1;
          state_d = tts_pkg::S_MUL;
        end
      end
      tts_pkg::S_POST: begin
        m_d   = 2'd0;
        acc_d = '0;
        case (task_q)
          tts_pkg::TK_DET: begin
            det_d = acc_q;
            j_d   = 2'd0;
            if (acc_q == '0) begin
              degen_d = 1'b1;
              for (int i = 0; i < 3; i++) begin
                tan_d[i] = '0;
                bit_d[i] = '0;
              end
              k_d     = 2'd0;
              wn_d    = n0_q;
              task_d  = tts_pkg::TK_DOT;
            end else begin
              degen_d = 1'b0;
              task_d  = tts_pkg::TK_TAN;
            end
            state_d = tts_pkg::S_MUL;
          end
          tts_pkg::TK_TAN, tts_pkg::TK_BIT: begin
            iter_req = '{start: 1'b1, op: tts_pkg::IT_DIV_LONG};
            iter_num = {abs_acc[tts_pkg::DEN_W-1:0], {tts_pkg::FRAC_BITS{1'b0}}};
            iter_den = abs_det[tts_pkg::DEN_W-1:0];
            neg_d    = acc_q[tts_pkg::ACC_W-1] ^ det_q[tts_pkg::ACC_W-1];
            state_d  = tts_pkg::S_ITER;
          end
          tts_pkg::TK_DOT: begin
            d_d     = tts_pkg::sat_coord(acc_q >>> tts_pkg::FRAC_BITS);
            j_d     = 2'd0;
            task_d  = tts_pkg::TK_ORT;
            state_d = tts_pkg::S_MUL;
          end
          tts_pkg::TK_ORT: begin
            tp_d[j_q] = tts_pkg::sat_coord(tts_pkg::ACC_W'(tan_q[j_q]) -
                                           (acc_q >>> tts_pkg::FRAC_BITS));
            if (j_q == 2'd2) begin
              task_d = tts_pkg::TK_SQT;
            end else begin
              j_d = j_q + 2'd1;
            end
            state_d = tts_pkg::S_MUL;
          end
          tts_pkg::TK_SQT, tts_pkg::TK_SQN: begin
            iter_req = '{start: 1'b1, op: tts_pkg::IT_SQRT};
            iter_num = {acc_q[2*CW-1:0], {(tts_pkg::NUM_W-2*CW){1'b0}}};
            state_d  = tts_pkg::S_ITER;
          end
          default: begin
            state_d = tts_pkg::S_IDLE;
          end
        endcase
      end
      tts_pkg::S_ITER: begin
        if (iter_stat.done) begin
          m_d   = 2'd0;
          acc_d = '0;
          case (task_q)
            tts_pkg::TK_TAN: begin
              tan_d[j_q] = tts_pkg::sat_quot(tri_quot, neg_q);
              task_d     = tts_pkg::TK_BIT;
              state_d    = tts_pkg::S_MUL;
            end
            tts_pkg::TK_BIT: begin
              bit_d[j_q] = tts_pkg::sat_quot(tri_quot, neg_q);
              if (j_q == 2'd2) begin
                k_d    = 2'd0;
                wn_d   = n0_q;
                task_d = tts_pkg::TK_DOT;
              end else begin
                j_d    = j_q + 2'd1;
                task_d = tts_pkg::TK_TAN;
              end
              state_d = tts_pkg::S_MUL;
            end
            default: begin
              len_d   = tri_quot[CW-1:0];
              j_d     = 2'd0;
              state_d = tts_pkg::S_UNIT;
            end
          endcase
        end
      end
      tts_pkg::S_UNIT: begin
        if (len_q == '0) begin
          if (task_q == tts_pkg::TK_SQT) ut_d[j_q] = '0;
          else                           un_d[j_q] = '0;
          if (j_q == 2'd2) begin
            j_d = 2'd0;
            if (task_q == tts_pkg::TK_SQT) begin
              task_d  = tts_pkg::TK_SQN;
              m_d     = 2'd0;
              acc_d   = '0;
              state_d = tts_pkg::S_MUL;
            end else begin
              state_d = tts_pkg::S_OUT;
            end
          end else begin
            j_d = j_q + 2'd1;
          end
        end else begin
          iter_req = '{start: 1'b1, op: tts_pkg::IT_DIV_SHORT};
          iter_num = {tts_pkg::mag_coord(uvec), {(tts_pkg::NUM_W-CW){1'b0}}};
          iter_den = tts_pkg::DEN_W'(len_q);
          state_d  = tts_pkg::S_UDIV;
        end
      end
      tts_pkg::S_UDIV: begin
        if (iter_stat.done) begin
          if (task_q == tts_pkg::TK_SQT) begin
            ut_d[j_q] = uvec[CW-1] ? -tri_quot[UW-1:0] : tri_quot[UW-1:0];
          end else begin
            un_d[j_q] = uvec[CW-1] ? -tri_quot[UW-1:0] : tri_quot[UW-1:0];
          end
          if (j_q == 2'd2) begin
            j_d = 2'd0;
            if (task_q == tts_pkg::TK_SQT) begin
              task_d  = tts_pkg::TK_SQN;
              m_d     = 2'd0;
              acc_d   = '0;
              state_d = tts_pkg::S_MUL;
            end else begin
              state_d = tts_pkg::S_OUT;
            end
          end else begin
            j_d     = j_q + 2'd1;
            state_d = tts_pkg::S_UNIT;
          end
        end
      end
      tts_pkg::S_OUT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          tdata_d = {{(tts_pkg::OUT_W-tts_pkg::OUT_BITS){1'b0}},
                     un_q[2], un_q[1], un_q[0],
                     bit_q[2], bit_q[1], bit_q[0],
                     ut_q[2], ut_q[1], ut_q[0]};
          tuser_d = degen_q;
          tlast_d = (k_q == 2'd2);
          if (k_q == 2'd2) begin
            state_d = tts_pkg::S_IDLE;
          end else begin
            k_d     = k_q + 2'd1;
            wn_d    = (k_q == 2'd0) ? n1_q : n2_q;
            task_d  = tts_pkg::TK_DOT;
            m_d     = 2'd0;
            acc_d   = '0;
            state_d = tts_pkg::S_MUL;
          end
        end
      end
      default: begin
        state_d = tts_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tts_pkg::S_IDLE;
      task_q      <= tts_pkg::TK_DET;
      phase_q     <= 2'd0;
      m_q         <= 2'd0;
      j_q         <= 2'd0;
      k_q         <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      task_q      <= task_d;
      phase_q     <= phase_d;
      m_q         <= m_d;
      j_q         <= j_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  // vertex capture by phase; a phase of 3 behaves as 0
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      for (int i = 0; i < 3; i++) begin
        if (phase_q == 2'd1) begin
          p1_q[i] <= s_axis_tdata[i*CW +: CW];
          n1_q[i] <= s_axis_tdata[(5+i)*CW +: CW];
        end else if (phase_q == 2'd2) begin
          p2_q[i] <= s_axis_tdata[i*CW +: CW];
          n2_q[i] <= s_axis_tdata[(5+i)*CW +: CW];
        end else begin
          p0_q[i] <= s_axis_tdata[i*CW +: CW];
          n0_q[i] <= s_axis_tdata[(5+i)*CW +: CW];
        end
      end
      for (int i = 0; i < 2; i++) begin
        if (phase_q == 2'd1)      uv1_q[i] <= s_axis_tdata[(3+i)*CW +: CW];
        else if (phase_q == 2'd2) uv2_q[i] <= s_axis_tdata[(3+i)*CW +: CW];
        else                      uv0_q[i] <= s_axis_tdata[(3+i)*CW +: CW];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tan_q   <= tan_d;
    bit_q   <= bit_d;
    tp_q    <= tp_d;
    wn_q    <= wn_d;
    ut_q    <= ut_d;
    un_q    <= un_d;
    d_q     <= d_d;
    acc_q   <= acc_d;
    det_q   <= det_d;
    len_q   <= len_d;
    degen_q <= degen_d;
    neg_q   <= neg_d;
    tdata_q <= tdata_d;
    tlast_q <= tlast_d;
    tuser_q <= tuser_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = tdata_q;
  assign m_axis_tuser  = tuser_q;
  assign m_axis_tlast  = tlast_q;

  `TTS_ASSERT(a_third_vertex_busy,
    s_axis_tvalid && s_axis_tready && (phase_q == 2'd2) |=> !s_axis_tready,
    "third vertex did not start the triangle")
  `TTS_ASSERT(a_degen_zero_bitangent,
    m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata[3*UW +: 3*CW] == '0),
    "degenerate result with nonzero bitangent")
  `TTS_ASSERT(a_unit_tangent_range,
    m_axis_tvalid |-> ($signed(m_axis_tdata[UW-1:0]) <= $signed(18'sd65536)) &&
                      ($signed(m_axis_tdata[UW-1:0]) >= $signed(-18'sd65536)),
    "unit tangent out of range")
  `TTS_ASSERT_ALWAYS(a_iter_start_idle,
    iter_req.start |-> !iter_stat.busy,
    "iterative unit restarted while busy")

endmodule
